// ===== rtl/core/tte_pkg.sv =====
// tte_pkg: shared types, constants and the microcode program of the tap tempo estimator
// no dependencies; used by the datapath, sequencer, top level, checker and testbench
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  localparam int unsigned HISTORY_DEFAULT = 8;

  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned GAP_W         = 12;
  localparam int unsigned Q_BITS        = 4;
  localparam int unsigned AVG_W         = 16;
  localparam int unsigned BPM_W         = 15;
  localparam int unsigned DELAY_W       = 15;
  localparam int unsigned BPM_NUM_W     = 20;

  localparam int unsigned GAP_MIN_EXCL  = 50;
  localparam int unsigned GAP_MAX_EXCL  = 3000;
  localparam int unsigned BPM_NUM_Q4    = 960000;
  localparam int unsigned DELAY_MIN_Q4  = 16;
  localparam int unsigned DELAY_MAX_Q4  = 32000;

  typedef struct packed {
    logic [STAMP_W-1:0] tap_time_ms;
  } tap_item_t;

  typedef struct packed {
    logic [AVG_W-1:0]   avg_interval_q4;
    logic [BPM_W-1:0]   bpm_q4;
    logic [DELAY_W-1:0] delay_ms_q4;
    logic               delay_valid;
  } result_t;

  typedef struct packed {
    logic sync_enabled;
  } cfg_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAP,
    OP_DIV_AVG,
    OP_DIV_BPM,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_FEW_TAPS,
    COND_ROT_MORE,
    COND_NO_GAP,
    COND_DIV_BUSY,
    COND_OUT_BLOCKED
  } cond_t;

  localparam int unsigned PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic few_taps;
    logic rot_more;
    logic no_gap;
    logic div_busy;
    logic out_blocked;
  } dp_status_t;

  localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK    = 4'd1;
  localparam logic [PC_W-1:0] PC_GAPS     = 4'd2;
  localparam logic [PC_W-1:0] PC_ANY      = 4'd3;
  localparam logic [PC_W-1:0] PC_AVG_GO   = 4'd4;
  localparam logic [PC_W-1:0] PC_AVG_WAIT = 4'd5;
  localparam logic [PC_W-1:0] PC_BPM_GO   = 4'd6;
  localparam logic [PC_W-1:0] PC_BPM_WAIT = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd9;

  // control store: operation, jump condition, jump target
  function automatic ctrl_word_t ucode_fetch(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_WAIT:     w = '{OP_LOAD,    COND_NO_IN,       PC_WAIT};
      PC_CHECK:    w = '{OP_NONE,    COND_FEW_TAPS,    PC_WAIT};
      PC_GAPS:     w = '{OP_GAP,     COND_ROT_MORE,    PC_GAPS};
      PC_ANY:      w = '{OP_NONE,    COND_NO_GAP,      PC_WAIT};
      PC_AVG_GO:   w = '{OP_DIV_AVG, COND_NONE,        PC_WAIT};
      PC_AVG_WAIT: w = '{OP_NONE,    COND_DIV_BUSY,    PC_AVG_WAIT};
      PC_BPM_GO:   w = '{OP_DIV_BPM, COND_NONE,        PC_WAIT};
      PC_BPM_WAIT: w = '{OP_NONE,    COND_DIV_BUSY,    PC_BPM_WAIT};
      PC_EMIT:     w = '{OP_EMIT,    COND_OUT_BLOCKED, PC_EMIT};
      PC_DONE:     w = '{OP_NONE,    COND_ALWAYS,      PC_WAIT};
      default:     w = '{OP_NONE,    COND_ALWAYS,      PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tte_stream_if.sv =====
// tte_stream_if: valid/ready channel carrying one payload of type T per transfer
// no dependencies; payload types come from tte_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tte_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

`default_nettype wire

// ===== rtl/core/tte_divider.sv =====
// tte_divider: restoring unsigned divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module tte_divider #(
  parameter int unsigned DIVD_W = 24,
  parameter int unsigned DIVS_W = 15
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   busy,
  output logic      [DIVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;
  logic              fits;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVD_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      busy_r <= cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      rem_r <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/tte_datapath.sv =====
// tte_datapath: tap history, gap accumulation, division operands and result register
// depends on tte_pkg and tte_stream_if; driven by the control word of tte_sequencer
`timescale 1ns / 1ps
`default_nettype none

module tte_datapath #(
  parameter int unsigned HISTORY = tte_pkg::HISTORY_DEFAULT,
  parameter int unsigned N_W     = $clog2(HISTORY),
  parameter int unsigned SUM_W   = tte_pkg::GAP_W + N_W,
  parameter int unsigned DIVD_W  = tte_pkg::BPM_NUM_W + N_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tte_pkg::ctrl_word_t  ctrl,
  tte_stream_if.sink                in_ch,
  tte_stream_if.source              out_ch,
  tte_stream_if.sink                cfg_ch,
  input  wire logic                 div_busy,
  input  wire logic    [DIVD_W-1:0] div_quo,
  output logic                      div_start,
  output logic         [DIVD_W-1:0] div_dividend,
  output logic         [SUM_W-1:0]  div_divisor,
  output tte_pkg::dp_status_t       status
);

  localparam int unsigned TAPS_W = $clog2(HISTORY + 1);
  localparam int unsigned CNT_W  = $clog2(HISTORY);
  localparam int unsigned SW     = tte_pkg::STAMP_W;

  logic [SW-1:0]                   hist_r [HISTORY];
  logic [TAPS_W-1:0]               taps_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [SUM_W-1:0]                sum_r;
  logic [N_W-1:0]                  n_r;
  logic [tte_pkg::AVG_W-1:0]       avg_r;
  logic                            sync_r;
  logic                            out_valid_r;
  tte_pkg::result_t                res_r;

  logic [SW-1:0]                   gap;
  logic                            gap_counts;
  logic                            in_xfer;
  logic                            out_blocked;
  logic [tte_pkg::DELAY_W-1:0]     delay_q4;
  logic [DIVD_W-1:0]               bpm_dividend;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_blocked = out_valid_r && !out_ch.ready;

  // gap between the two front entries; the history rotates so every pair passes here
  assign gap        = hist_r[0] - hist_r[1];
  assign gap_counts = (gap > SW'(tte_pkg::GAP_MIN_EXCL)) &&
                      (gap < SW'(tte_pkg::GAP_MAX_EXCL)) &&
                      ((TAPS_W'(cnt_r) + TAPS_W'(1)) < taps_r);

  assign bpm_dividend = DIVD_W'(tte_pkg::BPM_NUM_Q4) * DIVD_W'(n_r);

  always_comb begin
    if (avg_r > tte_pkg::AVG_W'(tte_pkg::DELAY_MAX_Q4)) begin
      delay_q4 = tte_pkg::DELAY_W'(tte_pkg::DELAY_MAX_Q4);
    end else if (avg_r < tte_pkg::AVG_W'(tte_pkg::DELAY_MIN_Q4)) begin
      delay_q4 = tte_pkg::DELAY_W'(tte_pkg::DELAY_MIN_Q4);
    end else begin
      delay_q4 = avg_r[tte_pkg::DELAY_W-1:0];
    end
  end

  always_comb begin
    div_start    = (ctrl.op == tte_pkg::OP_DIV_AVG) || (ctrl.op == tte_pkg::OP_DIV_BPM);
    div_dividend = bpm_dividend;
    div_divisor  = sum_r;
    if (ctrl.op == tte_pkg::OP_DIV_AVG) begin
      div_dividend = DIVD_W'({sum_r, {tte_pkg::Q_BITS{1'b0}}});
      div_divisor  = SUM_W'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r      <= '0;
      sync_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        sync_r <= cfg_ch.data.sync_enabled;
      end
      if (ctrl.op == tte_pkg::OP_EMIT && !out_blocked) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.op == tte_pkg::OP_LOAD && in_xfer && taps_r != TAPS_W'(HISTORY)) begin
        taps_r <= taps_r + TAPS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      tte_pkg::OP_LOAD: begin
        if (in_xfer) begin
          for (int k = HISTORY - 1; k > 0; k--) begin
            hist_r[k] <= hist_r[k-1];
          end
          hist_r[0] <= in_ch.data.tap_time_ms;
          cnt_r     <= '0;
          sum_r     <= '0;
          n_r       <= '0;
        end
      end
      tte_pkg::OP_GAP: begin
        for (int k = 0; k < HISTORY - 1; k++) begin
          hist_r[k] <= hist_r[k+1];
        end
        hist_r[HISTORY-1] <= hist_r[0];
        cnt_r             <= cnt_r + CNT_W'(1);
        if (gap_counts) begin
          sum_r <= sum_r + SUM_W'(gap[tte_pkg::GAP_W-1:0]);
          n_r   <= n_r + N_W'(1);
        end
      end
      tte_pkg::OP_DIV_BPM: begin
        avg_r <= div_quo[tte_pkg::AVG_W-1:0];
      end
      tte_pkg::OP_EMIT: begin
        if (!out_blocked) begin
          res_r.avg_interval_q4 <= avg_r;
          res_r.bpm_q4          <= div_quo[tte_pkg::BPM_W-1:0];
          res_r.delay_ms_q4     <= delay_q4;
          res_r.delay_valid     <= !sync_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready  = ctrl.op == tte_pkg::OP_LOAD;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  always_comb begin
    status.in_valid    = in_ch.valid;
    status.few_taps    = taps_r < TAPS_W'(2);
    status.rot_more    = cnt_r != CNT_W'(HISTORY - 1);
    status.no_gap      = n_r == '0;
    status.div_busy    = div_busy;
    status.out_blocked = out_blocked;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tte_sequencer.sv =====
// tte_sequencer: step counter over the microcode store with conditional jumps
// depends on tte_pkg for the control word, the program and the status flags
`timescale 1ns / 1ps
`default_nettype none

module tte_sequencer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tte_pkg::dp_status_t status,
  output tte_pkg::ctrl_word_t      ctrl
);

  logic [tte_pkg::PC_W-1:0] pc_r;
  logic [tte_pkg::PC_W-1:0] pc_nxt;
  logic                     jump;

  assign ctrl = tte_pkg::ucode_fetch(pc_r);

  always_comb begin
    case (ctrl.cond)
      tte_pkg::COND_NONE:        jump = 1'b0;
      tte_pkg::COND_ALWAYS:      jump = 1'b1;
      tte_pkg::COND_NO_IN:       jump = !status.in_valid;
      tte_pkg::COND_FEW_TAPS:    jump = status.few_taps;
      tte_pkg::COND_ROT_MORE:    jump = status.rot_more;
      tte_pkg::COND_NO_GAP:      jump = status.no_gap;
      tte_pkg::COND_DIV_BUSY:    jump = status.div_busy;
      tte_pkg::COND_OUT_BLOCKED: jump = status.out_blocked;
      default:                   jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + tte_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tte_pkg::PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tap_tempo_estimator.sv =====
// tap_tempo_estimator: top level, sequencer plus datapath plus shared divider
// depends on tte_pkg, tte_stream_if, tte_divider, tte_datapath, tte_sequencer
//
//   channel  | dir | payload                                         | transfer
//   in_ch    | in  | tap_time_ms                                     | valid && ready
//   out_ch   | out | avg_interval_q4, bpm_q4, delay_ms_q4, delay_valid | valid && ready
//   cfg_ch   | in  | sync_enabled                                    | valid && ready
//
// a tap with a result runs the gap walk, two serial divisions and the emit step, which waits
// while a previous result is stalled on out_ch, before the next in_ch.ready
// taps with no result return to ready after the tap check (first tap) or after the gap walk
// reset: synchronous active-low rst_n clears tap count, sync flag and result valid
// the result register holds while out_ch stalls; the next tap is taken meanwhile
// cfg_ch is always ready
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_estimator #(
  parameter int unsigned HISTORY = tte_pkg::HISTORY_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tte_stream_if.sink   in_ch,
  tte_stream_if.source out_ch,
  tte_stream_if.sink   cfg_ch
);

  localparam int unsigned N_W    = $clog2(HISTORY);
  localparam int unsigned SUM_W  = tte_pkg::GAP_W + N_W;
  localparam int unsigned DIVD_W = tte_pkg::BPM_NUM_W + N_W;

  tte_pkg::ctrl_word_t ctrl;
  tte_pkg::dp_status_t status;
  logic                div_start;
  logic                div_busy;
  logic [DIVD_W-1:0]   div_dividend;
  logic [SUM_W-1:0]    div_divisor;
  logic [DIVD_W-1:0]   div_quo;

  tte_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  tte_datapath #(
    .HISTORY (HISTORY),
    .N_W     (N_W),
    .SUM_W   (SUM_W),
    .DIVD_W  (DIVD_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .div_busy     (div_busy),
    .div_quo      (div_quo),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .status       (status)
  );

  tte_divider #(
    .DIVD_W (DIVD_W),
    .DIVS_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tte_checker.sv =====
// tte_checker: port-level assertions for tap_tempo_estimator, bound to the top level
// depends on tte_stream_if and tte_pkg
`timescale 1ns / 1ps
`default_nettype none

module tte_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire tte_pkg::result_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a tap transfer starts the program, so no tap is taken in the next cycle
  a_tap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("tap taken back to back");

  // a new result appears only from the emit step, never while waiting for taps
  a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised from the wait step");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ===== verif/tap_tempo_estimator_tb.sv =====
// tap_tempo_estimator_tb: self-checking testbench for the tap tempo estimator
// drives taps and sync settings over tte_stream_if channels and checks each result transfer
// depends on tte_pkg, tte_stream_if and tap_tempo_estimator
`timescale 1ns / 1ps

module tap_tempo_estimator_tb;

  localparam int unsigned SETTLE_CYCLES = 100;

  logic clk;
  logic rst_n;

  tte_stream_if #(.T(tte_pkg::tap_item_t)) in_if ();
  tte_stream_if #(.T(tte_pkg::result_t))   out_if ();
  tte_stream_if #(.T(tte_pkg::cfg_item_t)) cfg_if ();

  tap_tempo_estimator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [tte_pkg::STAMP_W-1:0] tap_log [tte_pkg::HISTORY_DEFAULT];
  int unsigned                 tap_count = 0;
  logic                        sync_on = 1'b0;
  tte_pkg::result_t            tempo_expected [$];

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned taps_sent = 0;
  int unsigned results_checked = 0;
  int unsigned sync_writes = 0;
  logic [tte_pkg::STAMP_W-1:0] last_stamp = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tap_tempo_estimator_tb failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < tte_pkg::HISTORY_DEFAULT; i++) tap_log[i] = '0;
  end

  // shift the tap into the history and queue the tempo it implies, if any
  task automatic log_tap(input logic [tte_pkg::STAMP_W-1:0] stamp);
    longint unsigned             gap_sum;
    longint unsigned             gaps;
    longint unsigned             avg;
    longint unsigned             bpm;
    longint unsigned             dly;
    logic [tte_pkg::STAMP_W-1:0] gap;
    tte_pkg::result_t            r;
    for (int i = tte_pkg::HISTORY_DEFAULT - 1; i > 0; i--) tap_log[i] = tap_log[i-1];
    tap_log[0] = stamp;
    if (tap_count < tte_pkg::HISTORY_DEFAULT) tap_count++;
    if (tap_count < 2) return;
    gap_sum = 0;
    gaps = 0;
    for (int i = 0; i + 1 < tap_count; i++) begin
      gap = tap_log[i] - tap_log[i+1];
      if (gap > tte_pkg::GAP_MIN_EXCL && gap < tte_pkg::GAP_MAX_EXCL) begin
        gap_sum += gap;
        gaps++;
      end
    end
    if (gaps == 0) return;
    avg = (gap_sum * 16) / gaps;
    bpm = (longint'(tte_pkg::BPM_NUM_Q4) * gaps) / gap_sum;
    dly = avg;
    if (dly > tte_pkg::DELAY_MAX_Q4) dly = tte_pkg::DELAY_MAX_Q4;
    if (dly < tte_pkg::DELAY_MIN_Q4) dly = tte_pkg::DELAY_MIN_Q4;
    r.avg_interval_q4 = avg[tte_pkg::AVG_W-1:0];
    r.bpm_q4          = bpm[tte_pkg::BPM_W-1:0];
    r.delay_ms_q4     = dly[tte_pkg::DELAY_W-1:0];
    r.delay_valid     = ~sync_on;
    tempo_expected = {tempo_expected, r};
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    tte_pkg::result_t want;
    tte_pkg::result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (tempo_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result avg %0d bpm %0d delay %0d valid %0d",
                                got.avg_interval_q4, got.bpm_q4, got.delay_ms_q4,
                                got.delay_valid));
      end else begin
        want = tempo_expected.pop_front();
        results_checked++;
        if (got.avg_interval_q4 !== want.avg_interval_q4)
          flag_mismatch($sformatf("avg_interval_q4 expected %0d actual %0d",
                                  want.avg_interval_q4, got.avg_interval_q4));
        if (got.bpm_q4 !== want.bpm_q4)
          flag_mismatch($sformatf("bpm_q4 expected %0d actual %0d",
                                  want.bpm_q4, got.bpm_q4));
        if (got.delay_ms_q4 !== want.delay_ms_q4)
          flag_mismatch($sformatf("delay_ms_q4 expected %0d actual %0d",
                                  want.delay_ms_q4, got.delay_ms_q4));
        if (got.delay_valid !== want.delay_valid)
          flag_mismatch($sformatf("delay_valid expected %0d actual %0d",
                                  want.delay_valid, got.delay_valid));
      end
    end
  end

  task automatic send_tap(input logic [tte_pkg::STAMP_W-1:0] stamp);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= tte_pkg::tap_item_t'(stamp);
    do @(posedge clk); while (!in_if.ready);
    log_tap(stamp);
    last_stamp = stamp;
    taps_sent++;
  endtask

  // wait for every queued result, then let a tap with no result finish
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (tempo_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= tte_pkg::cfg_item_t'(value);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sync_on = value;
    sync_writes++;
  endtask

  task automatic test_directed();
    logic [tte_pkg::STAMP_W-1:0] t;
    in_idle_pct   = 15;
    out_stall_pct = 82;
    write_sync(1'b0);
    // first tap, gap at the lower bound, just inside, upper edge, just outside
    send_tap(32'd0);
    send_tap(32'd50);
    send_tap(32'd101);
    send_tap(32'd3100);
    send_tap(32'd6100);
    // timestamp going backwards
    send_tap(32'd6000);
    // wrap across 2^32
    send_tap(32'hFFFF_FF00);
    send_tap(32'h0000_0100);
    // full history of slowest gaps, delay clamps at its maximum
    t = 32'h0000_0100;
    repeat (8) begin
      t = t + 32'd2999;
      send_tap(t);
    end
    send_tap(32'hFFFF_FFFF);
    settle_idle();
    // sync on, fastest counted gaps
    write_sync(1'b1);
    t = 32'hFFFF_FFFF;
    repeat (8) begin
      t = t + 32'd51;
      send_tap(t);
    end
  endtask

  task automatic test_random_taps(input int unsigned in_idle, input int unsigned out_stall,
                                  input logic sync_value, input int unsigned count);
    int unsigned                 sent;
    int unsigned                 beat;
    int unsigned                 run_len;
    int unsigned                 pick;
    int                          gap;
    logic [tte_pkg::STAMP_W-1:0] stamp;
    settle_idle();
    write_sync(sync_value);
    in_idle_pct   = in_idle;
    out_stall_pct = out_stall;
    sent = 0;
    last_stamp = $urandom();
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) beat = 51;
      else if (pick == 1) beat = 2999;
      else beat = $urandom_range(51, 2999);
      run_len = $urandom_range(3, 14);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        stamp = last_stamp;
        if (pick < 70) begin
          gap = int'(beat) + int'($urandom_range(0, 40)) - 20;
          stamp = last_stamp + gap;
        end else if (pick < 78) begin
          case ($urandom_range(0, 3))
            0: gap = 50;
            1: gap = 51;
            2: gap = 2999;
            default: gap = 3000;
          endcase
          stamp = last_stamp + gap;
        end else if (pick < 85) begin
          stamp = last_stamp + $urandom_range(0, 50);
        end else if (pick < 92) begin
          stamp = last_stamp + $urandom_range(3000, 200000);
        end else if (pick < 96) begin
          stamp = last_stamp - $urandom_range(1, 5000);
        end else begin
          stamp = $urandom();
        end
        send_tap(stamp);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_taps(15, 82, 1'b1, 300);
    test_random_taps(82, 15, 1'b0, 300);
    test_random_taps(0, 0, 1'b1, 150);
    test_random_taps(0, 0, 1'b0, 150);
    settle_idle();

    $display("summary: %0d taps sent under three idle profiles, %0d results checked",
             taps_sent, results_checked);
    $display("summary: %0d sync register writes covering on and off, %0d mismatches",
             sync_writes, mismatches);
    if (mismatches == 0) begin
      $display("tap_tempo_estimator_tb passed");
    end else begin
      $display("tap_tempo_estimator_tb failed");
    end
    $finish;
  end

endmodule
